[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cre_pkg.sv]
`default_nettype none

package cre_pkg;

   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] DIGIT_FIRST = 8'h30;
   localparam logic [7:0] DIGIT_LAST  = 8'h39;
   localparam logic [7:0] DASH        = 8'h2D;

   // character class, also used as the open range mode
   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_LOWER = 2'd1,
      CLS_DIGIT = 2'd2
   } char_class_type;

   // what deciding one text position produces
   typedef enum logic [1:0] {
      DEC_NONE   = 2'd0,
      DEC_SINGLE = 2'd1,
      DEC_RANGE  = 2'd2
   } dec_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECIDE = 2'd1,
      ST_EXPAND = 2'd2,
      ST_CLOSE  = 2'd3
   } cre_state_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic expand;
      logic close;
   } cre_cmd_type;

   typedef struct packed {
      logic         needs_work;
      dec_kind_type kind;
      logic         can_put;
      logic         can_close;
      logic         pos_last;
      logic         expand_done;
   } cre_status_type;

   function automatic char_class_type class_of(input logic [7:0] c);
      char_class_type k;
      if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
         k = CLS_LOWER;
      end else if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
         k = CLS_DIGIT;
      end else begin
         k = CLS_NONE;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/cre_channels.sv]
`default_nettype none

interface cre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_final;

   modport source (output valid, output in_byte, output in_final, input ready);
   modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface cre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       text_end;

   modport source (output valid, output out_byte, output run_end, output text_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input text_end,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/cre_ctrl.sv]
`default_nettype none

module cre_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire cre_pkg::cre_status_type status,
   output      cre_pkg::cre_cmd_type    cmd
);
   import cre_pkg::*;

   cre_state_type state_ff;
   cre_state_type state_in;
   logic          decide_go;

   assign decide_go = (status.kind != DEC_SINGLE) || status.can_put;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.needs_work) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_go) begin
               if (status.kind == DEC_RANGE) begin
                  state_in = ST_EXPAND;
               end else if (status.pos_last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_EXPAND: begin
            if (status.can_put && status.expand_done) begin
               state_in = status.pos_last ? ST_CLOSE : ST_DECIDE;
            end
         end
         ST_CLOSE: begin
            if (status.can_close) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECIDE: cmd.decide = decide_go;
         ST_EXPAND: cmd.expand = status.can_put;
         ST_CLOSE:  cmd.close  = status.can_close;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/cre_datapath.sv]
`default_nettype none

module cre_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    in_final,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_valid,
   output      logic [7:0]              out_byte,
   output      logic                    run_end,
   output      logic                    text_end,
   input  wire cre_pkg::cre_cmd_type    cmd,
   output      cre_pkg::cre_status_type status
);
   import cre_pkg::*;

   // lookahead window and range state
   logic [7:0]     win0_ff, win0_in, win1_ff, win1_in;
   logic [1:0]     fill_ff, fill_in;
   char_class_type mode_ff, mode_in;
   logic [7:0]     low_ff, low_in, high_ff, high_in;
   logic           skip_ff, skip_in;

   // positions of the current item
   logic [7:0]     seq0_ff, seq0_in, seq1_ff, seq1_in, seq2_ff, seq2_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic [1:0]     pos_ff, pos_in;
   logic [1:0]     last_ff, last_in;
   logic           fin_ff, fin_in;
   logic [7:0]     emit_ff, emit_in;

   // one byte held back so that the run end can be marked
   logic           hold_valid_ff, hold_valid_in;
   logic [7:0]     hold_ff, hold_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_run_ff, rsp_run_in;
   logic           rsp_text_ff, rsp_text_in;

   logic [7:0]     c0, c1, c2;
   char_class_type cls0, cls2;
   logic           dash1;
   logic [7:0]     new_low, new_high;
   dec_kind_type   kind;
   logic           out_free;
   logic           put_en;
   logic [7:0]     put_byte;

   // current position and its two lookahead bytes, zero past the end
   always_comb begin
      c0 = '0;
      c1 = '0;
      c2 = '0;
      case (pos_ff)
         2'd0: begin
            c0 = seq0_ff;
            c1 = (cnt_ff > 2'd1) ? seq1_ff : 8'd0;
            c2 = (cnt_ff > 2'd2) ? seq2_ff : 8'd0;
         end
         2'd1: begin
            c0 = seq1_ff;
            c1 = (cnt_ff > 2'd2) ? seq2_ff : 8'd0;
         end
         2'd2: c0 = seq2_ff;
         default: ;
      endcase
   end

   assign cls0     = class_of(c0);
   assign cls2     = class_of(c2);
   assign dash1    = (c1 == DASH);
   assign new_low  = (c0 < low_ff) ? c0 : low_ff;
   assign new_high = (c0 > high_ff) ? c0 : high_ff;

   always_comb begin
      if (skip_ff) begin
         kind = DEC_NONE;
      end else if (mode_ff == CLS_NONE) begin
         kind = (cls0 != CLS_NONE && dash1 && cls2 == cls0) ? DEC_NONE : DEC_SINGLE;
      end else begin
         kind = (dash1 && cls2 == mode_ff) ? DEC_NONE : DEC_RANGE;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign put_en   = (cmd.decide && kind == DEC_SINGLE) || cmd.expand;
   assign put_byte = cmd.expand ? emit_ff : c0;

   always_comb begin
      status.needs_work  = in_final || (fill_ff == 2'd2);
      status.kind        = kind;
      status.can_put     = !hold_valid_ff || out_free;
      status.can_close   = !hold_valid_ff || out_free;
      status.pos_last    = (pos_ff == last_ff);
      status.expand_done = (emit_ff == high_ff);
   end

   always_comb begin
      win0_in  = win0_ff;
      win1_in  = win1_ff;
      fill_in  = fill_ff;
      mode_in  = mode_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      skip_in  = skip_ff;
      seq0_in  = seq0_ff;
      seq1_in  = seq1_ff;
      seq2_in  = seq2_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      fin_in   = fin_ff;
      emit_in  = emit_ff;

      if (cmd.load) begin
         pos_in = 2'd0;
         fin_in = in_final;
         if (!in_final) begin
            if (fill_ff == 2'd0) begin
               win0_in = in_byte;
               fill_in = 2'd1;
            end else if (fill_ff == 2'd1) begin
               win1_in = in_byte;
               fill_in = 2'd2;
            end else begin
               seq0_in = win0_ff;
               seq1_in = win1_ff;
               seq2_in = in_byte;
               cnt_in  = 2'd3;
               last_in = 2'd0;
               win0_in = win1_ff;
               win1_in = in_byte;
            end
         end else begin
            // flush everything pending, window starts over
            case (fill_ff)
               2'd0: begin
                  seq0_in = in_byte;
                  cnt_in  = 2'd1;
                  last_in = 2'd0;
               end
               2'd1: begin
                  seq0_in = win0_ff;
                  seq1_in = in_byte;
                  cnt_in  = 2'd2;
                  last_in = 2'd1;
               end
               default: begin
                  seq0_in = win0_ff;
                  seq1_in = win1_ff;
                  seq2_in = in_byte;
                  cnt_in  = 2'd3;
                  last_in = 2'd2;
               end
            endcase
            win0_in = '0;
            win1_in = '0;
            fill_in = '0;
         end
      end

      if (cmd.decide) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else if (mode_ff == CLS_NONE) begin
            if (kind == DEC_NONE) begin
               low_in  = c0;
               high_in = c0;
               mode_in = cls0;
               skip_in = 1'b1;
            end
         end else begin
            low_in  = new_low;
            high_in = new_high;
            if (kind == DEC_NONE) begin
               skip_in = 1'b1;
            end else begin
               mode_in = CLS_NONE;
               emit_in = new_low;
            end
         end
         if (kind != DEC_RANGE) begin
            pos_in = pos_ff + 2'd1;
         end
      end

      if (cmd.expand) begin
         emit_in = emit_ff + 8'd1;
         if (emit_ff == high_ff) begin
            pos_in = pos_ff + 2'd1;
         end
      end

      if (cmd.close && fin_ff) begin
         mode_in = CLS_NONE;
         low_in  = '0;
         high_in = '0;
         skip_in = 1'b0;
      end
   end

   // hold stage and output register
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_text_in   = rsp_text_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (put_en) begin
         hold_valid_in = 1'b1;
         hold_in       = put_byte;
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = hold_ff;
            rsp_run_in   = 1'b0;
            rsp_text_in  = 1'b0;
         end
      end else if (cmd.close && hold_valid_ff) begin
         hold_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = hold_ff;
         rsp_run_in    = 1'b1;
         rsp_text_in   = fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff       <= '0;
         win1_ff       <= '0;
         fill_ff       <= '0;
         mode_ff       <= CLS_NONE;
         low_ff        <= '0;
         high_ff       <= '0;
         skip_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         win0_ff       <= win0_in;
         win1_ff       <= win1_in;
         fill_ff       <= fill_in;
         mode_ff       <= mode_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         skip_ff       <= skip_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq0_ff     <= seq0_in;
      seq1_ff     <= seq1_in;
      seq2_ff     <= seq2_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      fin_ff      <= fin_in;
      emit_ff     <= emit_in;
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_text_ff <= rsp_text_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_byte  = rsp_byte_ff;
   assign run_end   = rsp_run_ff;
   assign text_end  = rsp_text_ff;

endmodule

`default_nettype wire

[hw/rtl/char_range_expander.sv]
// character range expander
// req_ch carries one text byte per beat (in_byte, in_final); rsp_ch carries
// the expanded bytes (out_byte, run_end, text_end). a beat moves when valid
// and ready are both high.
// a byte is decided only once the two bytes after it have arrived, so the
// first two bytes of a text only fill the window and give no result.
// in_final flushes the window and ends the text.
// per accepted beat that needs work: the beat is accepted, each position is
// decided, each byte of an expanded range (up to 26) is put out, and the
// beat is closed; a new beat is accepted only after the previous one has
// closed, and the last byte of a beat reaches rsp_ch in the cycle after its
// closing step. the controller walks positions and range bytes one at a
// time through a single hold stage.
// req_ch.ready is high only between beats; results go through a hold byte
// and an output register, so a stalled receiver freezes the walk in place
// and nothing is lost or repeated.
// reset (synchronous, active high) empties the window, closes any open
// range and drops whatever result was waiting.
`default_nettype none

module char_range_expander (
   input  wire logic clock,
   input  wire logic reset,
   cre_req_if.sink   req_ch,
   cre_rsp_if.source rsp_ch
);
   import cre_pkg::*;

   cre_cmd_type    cmd;
   cre_status_type status;

   // controller: sequences load, decide, expand and close
   cre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: window, range bounds, hold byte and output register
   cre_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_ch.in_byte),
      .in_final  (req_ch.in_final),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .out_byte  (rsp_ch.out_byte),
      .run_end   (rsp_ch.run_end),
      .text_end  (rsp_ch.text_end),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

[hw/rtl/cre_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module cre_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_final,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte,
   input wire logic       rsp_run_end,
   input wire logic       rsp_text_end
);

   // a stalled result beat keeps its byte
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte), "result beat changed while stalled")

   // reset leaves no result pending
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result pending after reset")

   // the end of a text is also the end of its run
   `ASSERT_IMPLIES(a_text_run, clock, reset, rsp_valid && rsp_text_end, rsp_run_end, "text end without run end")

   // a final byte always starts a flush
   `ASSERT_NEXT(a_final_busy, clock, reset, req_valid && req_ready && req_final, !req_ready, "no flush after final byte")

endmodule

bind char_range_expander cre_checker u_cre_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_final    (req_ch.in_final),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_byte     (rsp_ch.out_byte),
   .rsp_run_end  (rsp_ch.run_end),
   .rsp_text_end (rsp_ch.text_end)
);

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cre_pkg::*;

   // cycles with no beat on either channel before the run is abandoned
   localparam int QUIET_LIMIT = 2000;
   // settling time after the last expected byte
   localparam int TAIL_CYCLES = 60;
   localparam int RANDOM_BYTES = 150;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       text_end;
   } out_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // tb-side copies of every block input, known from time zero
   logic       drv_valid = 1'b0;
   logic [7:0] drv_byte  = 8'h20;
   logic       drv_final = 1'b0;
   logic       drv_ready = 1'b0;

   cre_req_if req_ch ();
   cre_rsp_if rsp_ch ();

   assign req_ch.valid    = drv_valid;
   assign req_ch.in_byte  = drv_byte;
   assign req_ch.in_final = drv_final;
   assign rsp_ch.ready    = drv_ready;

   char_range_expander u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // text waiting to go out, and the expanded bytes still owed by the block
   text_beat_type text_to_send[$];
   out_beat_type  expected_bytes[$];
   out_beat_type  beat_bytes[$];

   int n_queued   = 0;
   int n_texts    = 0;
   int n_accepted = 0;
   int n_results  = 0;
   int n_errors   = 0;
   int n_ranges   = 0;
   int widest_run = 0;

   // shadow of the expander: two-byte lookahead, open range and its bounds
   logic [7:0]     lookahead [2];
   int             look_cnt  = 0;
   char_class_type open_cls  = CLS_NONE;
   logic [7:0]     span_lo   = 8'h00;
   logic [7:0]     span_hi   = 8'h00;
   logic           drop_dash = 1'b0;

   function automatic char_class_type byte_class(input logic [7:0] c);
      if (c >= LOWER_FIRST && c <= LOWER_LAST) return CLS_LOWER;
      if (c >= DIGIT_FIRST && c <= DIGIT_LAST) return CLS_DIGIT;
      return CLS_NONE;
   endfunction

   function automatic logic [7:0] class_byte(input char_class_type k);
      if (k == CLS_LOWER) return 8'($urandom_range(LOWER_FIRST, LOWER_LAST));
      return 8'($urandom_range(DIGIT_FIRST, DIGIT_LAST));
   endfunction

   // settle one text position once the two bytes after it are known
   task automatic settle_pos(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2);
      char_class_type k;
      int             v;
      k = byte_class(c0);
      if (drop_dash) begin
         // the dash of a range was already absorbed
         drop_dash = 1'b0;
      end else if (open_cls == CLS_NONE) begin
         if (k != CLS_NONE && c1 == DASH && byte_class(c2) == k) begin
            span_lo   = c0;
            span_hi   = c0;
            open_cls  = k;
            drop_dash = 1'b1;
         end else begin
            beat_bytes.push_back('{c0, 1'b0, 1'b0});
         end
      end else begin
         // inside a chain: widen the bounds, then either carry on or close
         if (c0 < span_lo) span_lo = c0;
         if (c0 > span_hi) span_hi = c0;
         if (c1 == DASH && byte_class(c2) == open_cls) begin
            drop_dash = 1'b1;
         end else begin
            for (v = span_lo; v <= span_hi; v++) begin
               beat_bytes.push_back('{8'(v), 1'b0, 1'b0});
            end
            n_ranges++;
            if (span_hi - span_lo + 1 > widest_run) widest_run = span_hi - span_lo + 1;
            open_cls = CLS_NONE;
         end
      end
   endtask

   // work out the bytes one accepted request beat owes, append to the store
   task automatic expand_beat(input logic [7:0] b, input logic fin);
      logic [7:0] seq [3];
      logic [7:0] n1;
      logic [7:0] n2;
      int         m;
      int         i;
      beat_bytes.delete();
      if (!fin) begin
         if (look_cnt < 2) begin
            // window still filling, nothing decided yet
            lookahead[look_cnt] = b;
            look_cnt++;
         end else begin
            settle_pos(lookahead[0], lookahead[1], b);
            lookahead[0] = lookahead[1];
            lookahead[1] = b;
         end
      end else begin
         // flush: positions past the end of text read as zero
         m = 0;
         for (i = 0; i < look_cnt; i++) begin
            seq[m] = lookahead[i];
            m++;
         end
         seq[m] = b;
         m++;
         for (i = 0; i < m; i++) begin
            n1 = (i + 1 < m) ? seq[i + 1] : 8'h00;
            n2 = (i + 2 < m) ? seq[i + 2] : 8'h00;
            settle_pos(seq[i], n1, n2);
         end
         look_cnt  = 0;
         open_cls  = CLS_NONE;
         span_lo   = 8'h00;
         span_hi   = 8'h00;
         drop_dash = 1'b0;
         if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size() - 1].text_end = 1'b1;
      end
      if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size() - 1].run_end = 1'b1;
      foreach (beat_bytes[j]) expected_bytes.push_back(beat_bytes[j]);
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      text_to_send.push_back('{b, fin});
      n_queued++;
      if (fin) n_texts++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
   endtask

   // request driver: per-beat idle gap, with calm stretches of back-to-back beats
   int   send_gap  = 0;
   logic send_calm = 1'b0;

   always @(posedge clock) begin
      text_beat_type nxt;
      if (reset) begin
         drv_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (drv_valid && req_ch.ready) begin
            expand_beat(drv_byte, drv_final);
            n_accepted++;
         end
         if (!drv_valid || req_ch.ready) begin
            if (send_gap > 0) begin
               drv_valid <= 1'b0;
               send_gap--;
            end else if (text_to_send.size() > 0) begin
               nxt = text_to_send.pop_front();
               drv_valid <= 1'b1;
               drv_byte  <= nxt.data;
               drv_final <= nxt.last;
               if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
               send_gap = send_calm ? 0 : $urandom_range(0, 15);
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each beat against the oldest owed byte, then
   // holds ready low for a drawn number of cycles
   int       stall_left = 0;
   logic     take_calm  = 1'b0;

   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         drv_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && drv_ready) begin
            n_results++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result: expected nothing, %s %h %s %b %s %b",
                        $time, "got byte", rsp_ch.out_byte, "run_end",
                        rsp_ch.run_end, "text_end", rsp_ch.text_end);
               n_errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.out_byte !== want.data) begin
                  $display("%0t: out_byte expected %h got %h",
                           $time, want.data, rsp_ch.out_byte);
                  n_errors++;
               end
               if (rsp_ch.run_end !== want.run_end) begin
                  $display("%0t: run_end expected %b got %b (byte %h)",
                           $time, want.run_end, rsp_ch.run_end, want.data);
                  n_errors++;
               end
               if (rsp_ch.text_end !== want.text_end) begin
                  $display("%0t: text_end expected %b got %b (byte %h)",
                           $time, want.text_end, rsp_ch.text_end, want.data);
                  n_errors++;
               end
            end
            if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
            stall_left = take_calm ? 0 : $urandom_range(0, 15);
         end
         if (stall_left > 0) begin
            drv_ready <= 1'b0;
            stall_left--;
         end else begin
            drv_ready <= 1'b1;
         end
      end
   end

   // watchdog on quiet cycles
   int quiet = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((drv_valid && req_ch.ready) || (rsp_ch.valid && drv_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d bytes still owed",
                     $time, QUIET_LIMIT, expected_bytes.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // bytes just outside the two classes, to probe the class boundaries
   logic [7:0] near_class [4] = '{8'h2F, 8'h3A, 8'h60, 8'h7B};

   initial begin
      int             tok;
      int             n_directed;
      char_class_type k;
      logic [7:0]     text_buf[$];

      // directed texts
      queue_text("a-z");          // widest lowercase run
      queue_text("b-k-c-e");      // chain with running min and max
      queue_text("9-0");          // reversed digit range
      queue_text("a-5");          // classes never mix
      queue_byte(8'hFF, 1'b1);    // one-byte text, window empty at flush
      queue_byte(8'h01, 1'b0);    // two-byte text
      queue_byte(DASH, 1'b1);
      queue_text("7-8-");         // trailing dash reads past the end
      n_directed = n_queued;

      // random texts: mostly well-formed ranges and chains, some noise
      while (n_queued < n_directed + RANDOM_BYTES) begin
         text_buf.delete();
         repeat ($urandom_range(1, 5)) begin
            tok = $urandom_range(0, 9);
            k   = ($urandom_range(0, 1) == 0) ? CLS_LOWER : CLS_DIGIT;
            if (tok <= 5) begin
               text_buf.push_back(class_byte(k));
               repeat ($urandom_range(1, 3)) begin
                  text_buf.push_back(DASH);
                  text_buf.push_back(class_byte(k));
               end
            end else if (tok <= 7) begin
               text_buf.push_back(8'($urandom_range(1, 255)));
            end else if (tok == 8) begin
               // broken range: mixed classes or a lone dash
               text_buf.push_back(class_byte(k));
               text_buf.push_back(DASH);
               if ($urandom_range(0, 1) == 0) begin
                  text_buf.push_back(class_byte(k == CLS_LOWER ? CLS_DIGIT : CLS_LOWER));
               end
            end else begin
               text_buf.push_back(near_class[$urandom_range(0, 3)]);
               text_buf.push_back(DASH);
               text_buf.push_back(class_byte(k));
            end
         end
         foreach (text_buf[i]) queue_byte(text_buf[i], i == text_buf.size() - 1);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < n_queued || expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d texts: %0d bytes in (%0d directed), %0d bytes out",
               n_texts, n_accepted, n_directed, n_results);
      $display("%0d ranges expanded, widest %0d bytes, %0d mismatches",
               n_ranges, widest_run, n_errors);
      if (n_errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
